### src/coons_patch_point_eval_defines.svh
// Assertion macros used only by the Coons patch evaluator back end.
`ifndef COONS_PATCH_POINT_EVAL_DEFINES_SVH
`define COONS_PATCH_POINT_EVAL_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define CPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/cpe_pkg.sv
// Types, constants and reciprocal table for the Coons patch evaluator.
`timescale 1ns / 1ps
package cpe_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int COORD_W     = 32;
	localparam int WFRAC       = 16;
	localparam int W_W         = WFRAC + 1;
	localparam int NUM_W       = IDX_W + WFRAC;
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int WPROD_W     = NUM_W + RECIP_W;
	localparam int PROD_W      = COORD_W + W_W + 1;
	localparam int SUM_W       = PROD_W + 4;
	localparam int RONE        = 1 << RECIP_SHIFT;

	localparam logic [W_W-1:0] W_ONE = W_W'(1 << WFRAC);

	// ceil(2^28 / d): exact floor division for numerators below 2^22 and d below 64
	localparam logic [RECIP_W-1:0] RECIP [MAX_POINTS] = '{
		'0,                 29'((RONE + 0) / 1),   29'((RONE + 1) / 2),   29'((RONE + 2) / 3),
		29'((RONE + 3) / 4),   29'((RONE + 4) / 5),   29'((RONE + 5) / 6),   29'((RONE + 6) / 7),
		29'((RONE + 7) / 8),   29'((RONE + 8) / 9),   29'((RONE + 9) / 10),  29'((RONE + 10) / 11),
		29'((RONE + 11) / 12), 29'((RONE + 12) / 13), 29'((RONE + 13) / 14), 29'((RONE + 14) / 15),
		29'((RONE + 15) / 16), 29'((RONE + 16) / 17), 29'((RONE + 17) / 18), 29'((RONE + 18) / 19),
		29'((RONE + 19) / 20), 29'((RONE + 20) / 21), 29'((RONE + 21) / 22), 29'((RONE + 22) / 23),
		29'((RONE + 23) / 24), 29'((RONE + 24) / 25), 29'((RONE + 25) / 26), 29'((RONE + 26) / 27),
		29'((RONE + 27) / 28), 29'((RONE + 28) / 29), 29'((RONE + 29) / 30), 29'((RONE + 30) / 31),
		29'((RONE + 31) / 32), 29'((RONE + 32) / 33), 29'((RONE + 33) / 34), 29'((RONE + 34) / 35),
		29'((RONE + 35) / 36), 29'((RONE + 36) / 37), 29'((RONE + 37) / 38), 29'((RONE + 38) / 39),
		29'((RONE + 39) / 40), 29'((RONE + 40) / 41), 29'((RONE + 41) / 42), 29'((RONE + 42) / 43),
		29'((RONE + 43) / 44), 29'((RONE + 44) / 45), 29'((RONE + 45) / 46), 29'((RONE + 46) / 47),
		29'((RONE + 47) / 48), 29'((RONE + 48) / 49), 29'((RONE + 49) / 50), 29'((RONE + 50) / 51),
		29'((RONE + 51) / 52), 29'((RONE + 52) / 53), 29'((RONE + 53) / 54), 29'((RONE + 54) / 55),
		29'((RONE + 55) / 56), 29'((RONE + 56) / 57), 29'((RONE + 57) / 58), 29'((RONE + 58) / 59),
		29'((RONE + 59) / 60), 29'((RONE + 60) / 61), 29'((RONE + 61) / 62), 29'((RONE + 62) / 63)
	};

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_EVAL = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		CURVE_C0 = 2'd0,
		CURVE_D0 = 2'd1,
		CURVE_C1 = 2'd2,
		CURVE_D1 = 2'd3
	} curve_t;

	localparam logic REG_S_COUNT = 1'b0;
	localparam logic REG_T_COUNT = 1'b1;

	// [2] x, [1] y, [0] z
	typedef logic [2:0][COORD_W-1:0] point_t;

	typedef struct packed {
		logic [IDX_W-1:0] s_last;
		logic [IDX_W-1:0] t_last;
	} cfg_t;

	typedef struct packed {
		req_t             req;
		curve_t           sel;
		logic [IDX_W-1:0] idx;
		point_t           pt;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] t;
		logic             oor;
		logic [NUM_W-1:0] s_num;
		logic [NUM_W-1:0] t_num;
	} item_t;

	typedef struct packed {
		point_t           pt;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] t;
		logic             oor;
	} result_t;

endpackage

### src/cpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpe_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/cpe_front.sv
// Front end: accepts items, range-checks their indices, queues all items for the back end.
`timescale 1ns / 1ps
module cpe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [1:0]                   curve_sel,
	input  logic [cpe_pkg::IDX_W-1:0]    point_index,
	input  logic signed [31:0]           x_in,
	input  logic signed [31:0]           y_in,
	input  logic signed [31:0]           z_in,
	input  logic [cpe_pkg::IDX_W-1:0]    s_index,
	input  logic [cpe_pkg::IDX_W-1:0]    t_index,
	input  cpe_pkg::cfg_t                cfg,
	output cpe_pkg::item_t               head,
	output logic                         head_valid,
	input  logic                         head_pop
);
	import cpe_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	item_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	item_t              item;
	logic               wr_en;

	always_comb begin
		item.req   = req_t'(req_type);
		item.sel   = curve_t'(curve_sel);
		item.idx   = point_index;
		item.pt    = {x_in, y_in, z_in};
		item.s     = s_index;
		item.t     = t_index;
		item.oor   = (s_index > cfg.s_last) || (t_index > cfg.t_last);
		// weight numerators i*ONE + d/2, divided in the back end
		item.s_num = {s_index, WFRAC'(0)} + NUM_W'(cfg.s_last >> 1);
		item.t_num = {t_index, WFRAC'(0)} + NUM_W'(cfg.t_last >> 1);
	end

	assign full       = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem_q[rd_ptr_q];
	assign wr_en      = push && !full;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(wr_en) - (QPTR_W + 1)'(head_pop);
		end
	end

endmodule

### src/cpe_back.sv
// Back end: curve stores, blend pipeline and result queue.
`timescale 1ns / 1ps
`include "coons_patch_point_eval_defines.svh"
module cpe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cpe_pkg::item_t   head,
	input  logic             head_valid,
	output logic             head_pop,
	input  cpe_pkg::cfg_t    cfg,
	output cpe_pkg::result_t res,
	output logic             empty,
	input  logic             pop
);
	import cpe_pkg::*;

	localparam int OUT_DEPTH = 8;
	localparam int OPTR_W    = $clog2(OUT_DEPTH);
	localparam int OCC_W     = OPTR_W + 2;

	logic issue, is_eval, room;
	logic we_c0, we_c1, we_d0, we_d1;
	point_t c0s, c1s, d0t, d1t, c0l, c1l;
	point_t c0_first_q, c1_first_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] s_s1, s_s2, s_s3, s_s4;
	logic [IDX_W-1:0] t_s1, t_s2, t_s3, t_s4;
	logic oor_s1, oor_s2, oor_s3, oor_s4;
	logic [WPROD_W-1:0] wsp_s1, wtp_s1;
	logic [W_W-1:0] ws, wt, omws, omwt, wt_s2, wt_s3, omwt3;

	logic signed [PROD_W-1:0] pc0_s2 [3], pc1_s2 [3], pd0_s2 [3], pd1_s2 [3];
	logic signed [PROD_W-1:0] pe00_s2 [3], pe0l_s2 [3], pe10_s2 [3], pe1l_s2 [3];
	logic signed [SUM_W-1:0]  lcld_s3 [3], lcld_s4 [3];
	logic [COORD_W-1:0]       e0_s3 [3], e1_s3 [3];
	logic signed [PROD_W-1:0] b0_s4 [3], b1_s4 [3];
	point_t                   fin;

	result_t           out_mem_q [OUT_DEPTH];
	logic [OPTR_W-1:0] owr_q, ord_q;
	logic [OPTR_W:0]   ocnt_q;
	logic [OCC_W-1:0]  occ;
	logic              out_push, out_pop;
	result_t           res_in;

	assign is_eval  = (head.req == REQ_EVAL);
	assign occ      = OCC_W'(ocnt_q) + OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3)
		+ OCC_W'(v_s4);
	assign room     = (occ < OCC_W'(OUT_DEPTH));
	assign issue    = head_valid && (!is_eval || room);
	assign head_pop = issue;

	assign we_c0 = issue && !is_eval && (head.sel == CURVE_C0);
	assign we_c1 = issue && !is_eval && (head.sel == CURVE_C1);
	assign we_d0 = issue && !is_eval && (head.sel == CURVE_D0);
	assign we_d1 = issue && !is_eval && (head.sel == CURVE_D1);

	// c0 and c1 are kept twice so the last point can be read beside the indexed one
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_c0_idx (
		.clk(clk), .we(we_c0), .waddr(head.idx), .wdata(head.pt),
		.raddr(head.s), .rdata(c0s));
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_c0_end (
		.clk(clk), .we(we_c0), .waddr(head.idx), .wdata(head.pt),
		.raddr(cfg.s_last), .rdata(c0l));
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_c1_idx (
		.clk(clk), .we(we_c1), .waddr(head.idx), .wdata(head.pt),
		.raddr(head.s), .rdata(c1s));
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_c1_end (
		.clk(clk), .we(we_c1), .waddr(head.idx), .wdata(head.pt),
		.raddr(cfg.s_last), .rdata(c1l));
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_d0 (
		.clk(clk), .we(we_d0), .waddr(head.idx), .wdata(head.pt),
		.raddr(head.t), .rdata(d0t));
	cpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_d1 (
		.clk(clk), .we(we_d1), .waddr(head.idx), .wdata(head.pt),
		.raddr(head.t), .rdata(d1t));

	// first points of c0 and c1 held in flops
	always_ff @(posedge clk) begin
		if (we_c0 && (head.idx == '0)) begin
			c0_first_q <= head.pt;
		end
		if (we_c1 && (head.idx == '0)) begin
			c1_first_q <= head.pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue && is_eval;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// weights: numerator times reciprocal of the clamped last index (count - 1)
	always_ff @(posedge clk) begin
		s_s1   <= head.s;
		t_s1   <= head.t;
		oor_s1 <= head.oor;
		wsp_s1 <= WPROD_W'(head.s_num) * WPROD_W'(RECIP[cfg.s_last]);
		wtp_s1 <= WPROD_W'(head.t_num) * WPROD_W'(RECIP[cfg.t_last]);
		s_s2   <= s_s1;
		t_s2   <= t_s1;
		oor_s2 <= oor_s1;
		wt_s2  <= wt;
		s_s3   <= s_s2;
		t_s3   <= t_s2;
		oor_s3 <= oor_s2;
		wt_s3  <= wt_s2;
		s_s4   <= s_s3;
		t_s4   <= t_s3;
		oor_s4 <= oor_s3;
	end

	assign ws    = wsp_s1[RECIP_SHIFT +: W_W];
	assign wt    = wtp_s1[RECIP_SHIFT +: W_W];
	assign omws  = W_ONE - ws;
	assign omwt  = W_ONE - wt;
	assign omwt3 = W_ONE - wt_s3;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		logic signed [PROD_W+1:0] e0_sum, e1_sum;
		logic signed [SUM_W-1:0]  f_sum;
		logic signed [SUM_W-WFRAC-1:0] f_q;

		assign e0_sum = (PROD_W + 2)'(pe00_s2[k]) + (PROD_W + 2)'(pe0l_s2[k])
			+ (PROD_W + 2)'(1 << (WFRAC - 1));
		assign e1_sum = (PROD_W + 2)'(pe10_s2[k]) + (PROD_W + 2)'(pe1l_s2[k])
			+ (PROD_W + 2)'(1 << (WFRAC - 1));
		assign f_sum  = lcld_s4[k] - SUM_W'(b0_s4[k]) - SUM_W'(b1_s4[k])
			+ SUM_W'(1 << (WFRAC - 1));
		assign f_q    = f_sum[SUM_W-1:WFRAC];

		always_comb begin
			if (f_q > (SUM_W - WFRAC)'(signed'(32'sh7FFFFFFF))) begin
				fin[k] = 32'h7FFFFFFF;
			end else if (f_q < (SUM_W - WFRAC)'(signed'(32'sh80000000))) begin
				fin[k] = 32'h80000000;
			end else begin
				fin[k] = f_q[COORD_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			pc0_s2[k]  <= $signed(c0s[k]) * $signed({1'b0, omwt});
			pc1_s2[k]  <= $signed(c1s[k]) * $signed({1'b0, wt});
			pd0_s2[k]  <= $signed(d0t[k]) * $signed({1'b0, omws});
			pd1_s2[k]  <= $signed(d1t[k]) * $signed({1'b0, ws});
			pe00_s2[k] <= $signed(c0_first_q[k]) * $signed({1'b0, omws});
			pe0l_s2[k] <= $signed(c0l[k]) * $signed({1'b0, ws});
			pe10_s2[k] <= $signed(c1_first_q[k]) * $signed({1'b0, omws});
			pe1l_s2[k] <= $signed(c1l[k]) * $signed({1'b0, ws});

			lcld_s3[k] <= SUM_W'(pc0_s2[k]) + SUM_W'(pc1_s2[k])
				+ SUM_W'(pd0_s2[k]) + SUM_W'(pd1_s2[k]);
			e0_s3[k]   <= e0_sum[WFRAC +: COORD_W];
			e1_s3[k]   <= e1_sum[WFRAC +: COORD_W];

			lcld_s4[k] <= lcld_s3[k];
			b0_s4[k]   <= $signed(e0_s3[k]) * $signed({1'b0, omwt3});
			b1_s4[k]   <= $signed(e1_s3[k]) * $signed({1'b0, wt_s3});
		end
	end

	// result queue
	assign out_push  = v_s4;
	assign out_pop   = pop && !empty;
	assign res_in.pt = oor_s4 ? '0 : fin;
	assign res_in.s  = s_s4;
	assign res_in.t  = t_s4;
	assign res_in.oor = oor_s4;
	assign empty     = (ocnt_q == '0);
	assign res       = out_mem_q[ord_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem_q[owr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (out_push) begin
				owr_q <= owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (OPTR_W + 1)'(out_push) - (OPTR_W + 1)'(out_pop);
		end
	end

	`CPE_ASSERT_IMP(a_out_no_overflow, clk, arst_n, out_push && !out_pop, ocnt_q != (OPTR_W + 1)'(OUT_DEPTH), "result queue overflow")
	`CPE_ASSERT_IMP(a_eval_has_room, clk, arst_n, issue && is_eval, occ < OCC_W'(OUT_DEPTH), "evaluation issued without result room")
	`CPE_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ <= OCC_W'(OUT_DEPTH), "results in flight exceed queue depth")
	`CPE_ASSERT_NXT(a_eval_reaches_queue, clk, arst_n, v_s3, out_push, "evaluation lost in pipeline")

endmodule

### src/coons_patch_point_eval.sv
// Top level of the Coons patch point evaluator: configuration registers and front/back ends.
//
//  channel   handshake                   moves
//  --------  --------------------------  ---------------------------------------------
//  config    psel/penable/pwrite/pready  s_count (0x0), t_count (0x4)
//  items     push / full                 load point or evaluate request
//  results   pop / empty                 x/y/z_out, s_echo, t_echo, out_of_range
//
// One item is taken per cycle while the head is not an evaluation held for result room; an
// evaluation then passes store read with weight multiply, blend products, corner round and
// sum, corner blend multiply, then the final round/saturate in front of the result queue.
// Loads produce no result and write the curve stores as they are taken, even while
// queued and in-flight results fill the result queue and hold evaluations in the 4-entry
// input queue. Reset sets the counts to 2 and empties both queues, not the curve stores.
`timescale 1ns / 1ps
module coons_patch_point_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic               req_type,
	input  logic [1:0]         curve_sel,
	input  logic [5:0]         point_index,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic signed [31:0] z_in,
	input  logic [5:0]         s_index,
	input  logic [5:0]         t_index,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic [5:0]         s_echo,
	output logic [5:0]         t_echo,
	output logic               out_of_range
);
	import cpe_pkg::*;

	logic [CNT_W-1:0] s_count_q, t_count_q;
	logic             reg_wr;
	cfg_t             cfg;
	item_t            head;
	logic             head_valid, head_pop;
	result_t          res;

	function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] n);
		if (n < CNT_W'(2)) begin
			return IDX_W'(1);
		end else if (n > CNT_W'(MAX_POINTS)) begin
			return IDX_W'(MAX_POINTS - 1);
		end
		return IDX_W'(n - CNT_W'(1));
	endfunction

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_count_q <= CNT_W'(2);
			t_count_q <= CNT_W'(2);
		end else if (reg_wr) begin
			case (paddr[2])
				REG_S_COUNT: s_count_q <= pwdata[CNT_W-1:0];
				REG_T_COUNT: t_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_S_COUNT: prdata = 32'(s_count_q);
			REG_T_COUNT: prdata = 32'(t_count_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.s_last = last_index(s_count_q);
	assign cfg.t_last = last_index(t_count_q);

	cpe_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .curve_sel(curve_sel), .point_index(point_index),
		.x_in(x_in), .y_in(y_in), .z_in(z_in), .s_index(s_index), .t_index(t_index),
		.cfg(cfg), .head(head), .head_valid(head_valid), .head_pop(head_pop)
	);

	cpe_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.head_pop(head_pop), .cfg(cfg), .res(res), .empty(empty), .pop(pop)
	);

	assign x_out        = res.pt[2];
	assign y_out        = res.pt[1];
	assign z_out        = res.pt[0];
	assign s_echo       = res.s;
	assign t_echo       = res.t;
	assign out_of_range = res.oor;

endmodule
